FILE: rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
		32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
		32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
		32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
		32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
		32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
		32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
		32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
		32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
		32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
		32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
	};

	localparam logic [255:0] H_INIT = {
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_stream_hasher.sv
`default_nettype none
// channel | dir | fields
// s_axis  | in  | tdata[7:0] data_byte, tuser[1:0] {end_of_message,byte_valid}
// m_axis  | out | tdata[255:0] digest_word0..3 (word0 lowest)
// Bytes land in a 64x8 RAM (one write per cycle while accepting input or
// padding; registered read). A full block is shifted out of the RAM into a
// block register, then 64 rounds run, one per cycle, then the ADD state adds
// into the hash; padding adds at most one block at the end.
// Reset restores initial hash, clears fill and bit count; RAM is not cleared.
// Input stalls during padding, compression and while the digest waits on m_axis.
module sha256_stream_hasher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // data_byte
	input  wire logic [1:0]   s_axis_tuser,  // byte_valid, end_of_message
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [255:0] m_axis_tdata   // digest_word0,1,2,3
);
	import sha256_pkg::*;

	logic [7:0] mem [64];
	logic [7:0] rd_s1;
	logic       we;
	logic [5:0] wa, ra;
	logic [7:0] wd;

	state_t st_q, st_d;
	logic [5:0]  fill_q, cnt_q;
	logic [63:0] bits_q;
	logic [255:0] hash_q;
	logic [503:0] blk_q;
	logic        last_q, two_q, rd_s2;
	logic [255:0] vars;
	logic        acc;

	assign s_axis_tready = (st_q == ST_FILL);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {hash_q[63:0], hash_q[127:64], hash_q[191:128], hash_q[255:192]};

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_s1 <= mem[ra];
	end

	// pad byte source for position cnt_q during ST_PAD
	logic [63:0] total;
	logic [2:0]  lenidx;
	assign total = bits_q;
	assign lenidx = cnt_q[2:0];   // length byte index at positions 56..63

	always_comb begin
		we = 1'b0; wa = fill_q; wd = s_axis_tdata; ra = cnt_q;
		st_d = st_q;
		unique case (st_q)
			ST_FILL: if (acc) begin
				we = s_axis_tuser[0];
				if (s_axis_tuser[0] && fill_q == 6'd63) st_d = ST_LOAD;
				else if (s_axis_tuser[1]) st_d = ST_PAD;
			end
			ST_PAD: begin
				we = 1'b1; wa = cnt_q;
				if (cnt_q == fill_q && !two_q) wd = PAD_BYTE;
				else if (cnt_q >= 6'd56 && !(fill_q >= 6'd56 && !two_q))
					wd = total[63 - 8*lenidx -: 8];
				else wd = 8'h00;
				if (cnt_q == 6'd63) st_d = ST_LOAD;
			end
			ST_LOAD: begin
				// read one address ahead once the first byte is in flight
				ra = cnt_q + {5'd0, rd_s2};
				if (cnt_q == 6'd63 && rd_s2) st_d = ST_ROUND;
			end
			ST_ROUND: if (cnt_q == 6'd63) st_d = ST_ADD;
			ST_ADD: st_d = last_q ? ST_OUT
				: ((two_q || fill_q >= 6'd56) ? ST_PAD : ST_FILL);
			ST_OUT: if (m_axis_tready) st_d = ST_FILL;
			default: st_d = ST_FILL;
		endcase
	end

	logic [255:0] sum;
	always_comb
		for (int i = 0; i < 8; i++)
			sum[32*i +: 32] = hash_q[32*i +: 32] + vars[32*i +: 32];

	sha256_round u_rnd (
		.clk(clk), .load(st_q == ST_LOAD && st_d == ST_ROUND),
		.step(st_q == ST_ROUND), .rnd(cnt_q), .hash_in(hash_q),
		.block_in({blk_q, rd_s1}), .vars(vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_FILL; fill_q <= '0; cnt_q <= '0; bits_q <= '0;
			hash_q <= H_INIT; last_q <= 1'b0; two_q <= 1'b0; rd_s2 <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_FILL: if (acc) begin
					if (s_axis_tuser[0]) begin
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					// end marker with a full block: pad after compressing
					two_q <= s_axis_tuser[0] && fill_q == 6'd63 && s_axis_tuser[1];
					last_q <= s_axis_tuser[1] && !(s_axis_tuser[0] && fill_q == 6'd63)
						&& (fill_q + {5'd0, s_axis_tuser[0]}) < 6'd56;
					// padding starts right after the last byte
					cnt_q <= fill_q + {5'd0, s_axis_tuser[0]};
					rd_s2 <= 1'b0;
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 6'd1;
					rd_s2 <= 1'b0;
				end
				ST_LOAD: begin
					rd_s2 <= 1'b1;
					if (rd_s2) blk_q <= {blk_q[495:0], rd_s1};
					if (st_d == ST_ROUND) cnt_q <= '0;
					else if (rd_s2) cnt_q <= cnt_q + 6'd1;
				end
				ST_ROUND: cnt_q <= cnt_q + 6'd1;
				ST_ADD: begin
					hash_q <= sum;
					cnt_q <= '0;
					if (two_q) begin
						// full block ended message: pad block next, pad byte at 0
						fill_q <= '0; two_q <= 1'b0; last_q <= 1'b1;
					end else if (!last_q && fill_q >= 6'd56) begin
						// first pad block done: length block follows
						fill_q <= '0; two_q <= 1'b1; last_q <= 1'b1;
					end else if (!last_q) fill_q <= '0;
				end
				ST_OUT: if (m_axis_tready) begin
					hash_q <= H_INIT; bits_q <= '0; fill_q <= '0;
					last_q <= 1'b0; two_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/sha256_round.sv
`default_nettype none
// One compression round with a 16-word rolling message schedule.
module sha256_round (
	input  wire logic         clk,
	input  wire logic         load,   // load vars from hash, words from block
	input  wire logic         step,
	input  wire logic [5:0]   rnd,
	input  wire logic [255:0] hash_in,
	input  wire logic [511:0] block_in,
	output logic      [255:0] vars
);
	import sha256_pkg::*;

	logic [31:0] w_q [16];
	logic [255:0] v_q;
	logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wn, s0, s1;

	always_comb begin
		{a, b, c, d, e, f, g, h} = v_q;
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ K_TAB[rnd] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= hash_in;
			for (int i = 0; i < 16; i++) w_q[i] <= block_in[511 - 32*i -: 32];
		end else if (step) begin
			v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
		end
	end

	assign vars = v_q;
endmodule
`default_nettype wire
